/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/core/rtpw_pkg.sv */
// ----------------------------------------------------------------------------
// rtpw_pkg
// Shared widths, defaults, rotation codes and state type for the pixel writer.
// ----------------------------------------------------------------------------
package rtpw_pkg;

    localparam int PANEL_WIDTH_DEF  = 400;
    localparam int PANEL_HEIGHT_DEF = 300;

    localparam int COORD_W    = 16;
    localparam int GRAY_W     = 2;
    localparam int ROT_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int OUT_ADDR_W = 14;

    localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_WRITE
    } t_state;

endpackage

/* rtl/core/rtpw_chan_if.sv */
// ----------------------------------------------------------------------------
// rtpw channel interfaces
// Valid/ready channels for pixel write beats and result beats.
// ----------------------------------------------------------------------------
interface rtpw_in_if import rtpw_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [GRAY_W-1:0]         gray_level;

    modport source (output valid, output pixel_x, output pixel_y, output gray_level,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input gray_level,
                    output ready);
endinterface

interface rtpw_out_if import rtpw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  written;
    logic [OUT_ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0]     new_black_byte;
    logic [BYTE_W-1:0]     new_color_byte;

    modport source (output valid, output written, output byte_address,
                    output new_black_byte, output new_color_byte, input ready);
    modport sink   (input valid, input written, input byte_address,
                    input new_black_byte, input new_color_byte, output ready);
endinterface

/* rtl/core/rotated_two_plane_pixel_writer_top.sv */
// ----------------------------------------------------------------------------
// rotated_two_plane_pixel_writer_top
// Clips, rotates and writes one 2-bit pixel into black and color bit planes.
// ----------------------------------------------------------------------------
// After reset the block sweeps both frame stores to zero, one byte a cycle,
// over all (PANEL_WIDTH*PANEL_HEIGHT+7)/8 bytes (15000 at the default 400x300
// panel); no pixel beat is taken during the sweep, rotation writes are.
// A pixel then passes four states: accept with clip and rotation, linear index
// multiply, frame store read, modify and write back into the result register.
// The next beat is taken once the write back is done; the four-state sequence
// with no overlap between pixels sets that pace. A finished result waits in
// the output register without holding off the next pixel beat. Rotation is
// sampled when a beat is accepted. Clipped pixels return a result of all zeros.
`include "assert_macros.svh"

module rotated_two_plane_pixel_writer_top import rtpw_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [ROT_W-1:0] i_cfg_wdata,
    rtpw_in_if.sink          i_pix,
    rtpw_out_if.source       o_res
);

    localparam int PIXELS      = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int PLANE_BYTES = (PIXELS + 7) / 8;
    localparam int IDX_W       = $clog2(PIXELS);
    localparam int ADDR_W      = IDX_W - 3;
    localparam int COL_W       = $clog2(PANEL_WIDTH);
    localparam int ROW_W       = $clog2(PANEL_HEIGHT);

    localparam logic [COORD_W-1:0] W16    = COORD_W'(PANEL_WIDTH);
    localparam logic [COORD_W-1:0] H16    = COORD_W'(PANEL_HEIGHT);
    localparam logic [COORD_W-1:0] W_M1   = COORD_W'(PANEL_WIDTH - 1);
    localparam logic [COORD_W-1:0] H_M1   = COORD_W'(PANEL_HEIGHT - 1);
    localparam logic [IDX_W-1:0]   H_IDX  = IDX_W'(PANEL_HEIGHT);
    localparam logic [ADDR_W-1:0]  CLR_LAST = ADDR_W'(PLANE_BYTES - 1);

    // frame stores
    logic [BYTE_W-1:0] black_mem [PLANE_BYTES];
    logic [BYTE_W-1:0] color_mem [PLANE_BYTES];

    t_state r_state, n_state;
    logic [ROT_W-1:0]  r_rot;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_in_panel;
    logic [GRAY_W-1:0] r_gray;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_rd_black, r_rd_color;

    logic                  r_out_valid;
    logic                  r_out_written;
    logic [OUT_ADDR_W-1:0] r_out_addr;
    logic [BYTE_W-1:0]     r_out_black, r_out_color;

    logic in_ready, clr_we, rd_en, wb_en;

    logic [COORD_W-1:0] xu, yu, lw, lh, col16, row16;
    logic               in_panel;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ADDR_W+OUT_ADDR_W-1:0] addr_ext;
    logic [BYTE_W-1:0]  bit_mask, new_black, new_color;

    // clip and rotate
    always_comb begin
        xu = $unsigned(i_pix.pixel_x);
        yu = $unsigned(i_pix.pixel_y);
        if (r_rot == ROT_90 || r_rot == ROT_270) begin
            lw = H16;
            lh = W16;
        end else begin
            lw = W16;
            lh = H16;
        end
        in_panel = !i_pix.pixel_x[COORD_W-1] && !i_pix.pixel_y[COORD_W-1] &&
                   (xu < lw) && (yu < lh);
        // col is the mirrored physical x: PANEL_WIDTH-1-px
        case (r_rot)
            ROT_NONE: begin
                col16 = W_M1 - xu;
                row16 = yu;
            end
            ROT_90: begin
                col16 = yu;
                row16 = xu;
            end
            ROT_180: begin
                col16 = xu;
                row16 = H_M1 - yu;
            end
            ROT_270: begin
                col16 = W_M1 - yu;
                row16 = H_M1 - xu;
            end
            default: begin
                col16 = W_M1 - xu;
                row16 = yu;
            end
        endcase
    end

    assign mem_addr = r_idx[IDX_W-1:3];
    assign addr_ext = (ADDR_W+OUT_ADDR_W)'(mem_addr);
    assign bit_mask = 8'h80 >> r_idx[2:0];
    assign new_black = r_gray[0] ? (r_rd_black | bit_mask) : (r_rd_black & ~bit_mask);
    assign new_color = r_gray[1] ? (r_rd_color | bit_mask) : (r_rd_color & ~bit_mask);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_pix.valid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        clr_we   = 1'b0;
        rd_en    = 1'b0;
        wb_en    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                clr_we = 1'b1;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_CALC: begin
            end
            ST_READ: begin
                rd_en = r_in_panel;
            end
            ST_WRITE: begin
                wb_en = !r_out_valid || o_res.ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rot       <= ROT_NONE;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_rot <= i_cfg_wdata;
            end
            if (clr_we) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (wb_en) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_ready && i_pix.valid) begin
            r_in_panel <= in_panel;
            r_gray     <= i_pix.gray_level;
            r_col      <= col16[COL_W-1:0];
            r_row      <= row16[ROW_W-1:0];
        end
        if (r_state == ST_CALC) begin
            r_idx <= IDX_W'(r_col) * H_IDX + IDX_W'(r_row);
        end
        if (wb_en) begin
            r_out_written <= r_in_panel;
            r_out_addr    <= r_in_panel ? addr_ext[OUT_ADDR_W-1:0] : '0;
            r_out_black   <= r_in_panel ? new_black : '0;
            r_out_color   <= r_in_panel ? new_color : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_we) begin
            black_mem[r_clr_addr] <= '0;
            color_mem[r_clr_addr] <= '0;
        end else if (wb_en && r_in_panel) begin
            black_mem[mem_addr] <= new_black;
            color_mem[mem_addr] <= new_color;
        end
        if (rd_en) begin
            r_rd_black <= black_mem[mem_addr];
            r_rd_color <= color_mem[mem_addr];
        end
    end

    assign i_pix.ready          = in_ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.written        = r_out_written;
    assign o_res.byte_address   = r_out_addr;
    assign o_res.new_black_byte = r_out_black;
    assign o_res.new_color_byte = r_out_color;

    `ASSERT_PROP(a_accept_to_calc, i_clk, i_rst_n, (i_pix.valid && in_ready) |=> (r_state == ST_CALC), "accepted beat did not start index calc")
    `ASSERT_PROP(a_read_to_write, i_clk, i_rst_n, (r_state == ST_READ) |=> (r_state == ST_WRITE), "read not followed by write back")
    `ASSERT_PROP(a_clear_holds, i_clk, i_rst_n, (r_state == ST_CLEAR && r_clr_addr != CLR_LAST) |=> (r_state == ST_CLEAR), "clear sweep left early")
    `ASSERT_NEVER(a_clipped_zero, i_clk, i_rst_n, r_out_valid && !r_out_written && (r_out_addr != '0 || r_out_black != '0 || r_out_color != '0), "clipped result not zero")

endmodule

/* tb/rtpw_pixel_write_checker.sv */
// ----------------------------------------------------------------------------
// rtpw_pixel_write_checker
// Watches the pixel and result channels, models the two bit-plane frame
// stores under the current rotation and compares every result beat.
// ----------------------------------------------------------------------------
module rtpw_pixel_write_checker import rtpw_pkg::*; #(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [ROT_W-1:0] i_cfg_wdata,
    rtpw_in_if               i_pix,
    rtpw_out_if              i_res,
    output int               o_pending,
    output int               o_mismatches,
    output int               o_checked,
    output int               o_clipped
);

    localparam int PLANE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;

    typedef struct packed {
        logic                  written;
        logic [OUT_ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0]     black_byte;
        logic [BYTE_W-1:0]     color_byte;
    } t_pixel_result;

    logic [BYTE_W-1:0] black_store [PLANE_BYTES];
    logic [BYTE_W-1:0] color_store [PLANE_BYTES];
    logic [ROT_W-1:0]  rotation_q;
    t_pixel_result     pending_results[$];
    t_pixel_result     want;
    int                k;

    initial begin
        o_pending    = 0;
        o_mismatches = 0;
        o_checked    = 0;
        o_clipped    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    // clip, rotate, then read-modify-write one bit in each plane
    function automatic t_pixel_result apply_pixel_write(
        input logic signed [COORD_W-1:0] x_in,
        input logic signed [COORD_W-1:0] y_in,
        input logic [GRAY_W-1:0]         gray,
        input logic [ROT_W-1:0]          rot
    );
        int                x, y, lw, lh, px, py, lin, addr;
        logic [BYTE_W-1:0] bitmask, bk, cl;
        t_pixel_result     r;
        r  = '0;
        x  = x_in;
        y  = y_in;
        lw = PANEL_WIDTH;
        lh = PANEL_HEIGHT;
        if (rot == ROT_90 || rot == ROT_270) begin
            lw = PANEL_HEIGHT;
            lh = PANEL_WIDTH;
        end
        if (x < 0 || x >= lw || y < 0 || y >= lh)
            return r;
        case (rot)
            ROT_90: begin
                px = PANEL_WIDTH - 1 - y;
                py = x;
            end
            ROT_180: begin
                px = PANEL_WIDTH - 1 - x;
                py = PANEL_HEIGHT - 1 - y;
            end
            ROT_270: begin
                px = y;
                py = PANEL_HEIGHT - 1 - x;
            end
            default: begin
                px = x;
                py = y;
            end
        endcase
        lin  = (PANEL_WIDTH - 1 - px) * PANEL_HEIGHT + py;
        addr = lin >> 3;
        if (addr >= PLANE_BYTES)
            return r;
        bitmask = 8'h80 >> lin[2:0];
        bk = black_store[addr];
        cl = color_store[addr];
        bk = gray[0] ? (bk | bitmask) : (bk & ~bitmask);
        cl = gray[1] ? (cl | bitmask) : (cl & ~bitmask);
        black_store[addr] = bk;
        color_store[addr] = cl;
        r.written      = 1'b1;
        r.byte_address = addr[OUT_ADDR_W-1:0];
        r.black_byte   = bk;
        r.color_byte   = cl;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rotation_q = ROT_NONE;
            pending_results.delete();
            for (k = 0; k < PLANE_BYTES; k++) begin
                black_store[k] = '0;
                color_store[k] = '0;
            end
        end else begin
            if (i_res.valid && i_res.ready) begin
                o_checked++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending");
                end else begin
                    want = pending_results.pop_front();
                    if (i_res.written !== want.written)
                        report_mismatch($sformatf("written got %0b expected %0b",
                                                  i_res.written, want.written));
                    if (i_res.byte_address !== want.byte_address)
                        report_mismatch($sformatf("byte_address got %0d expected %0d",
                                                  i_res.byte_address, want.byte_address));
                    if (i_res.new_black_byte !== want.black_byte)
                        report_mismatch($sformatf("new_black_byte got %02h expected %02h",
                                                  i_res.new_black_byte, want.black_byte));
                    if (i_res.new_color_byte !== want.color_byte)
                        report_mismatch($sformatf("new_color_byte got %02h expected %02h",
                                                  i_res.new_color_byte, want.color_byte));
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                want = apply_pixel_write(i_pix.pixel_x, i_pix.pixel_y, i_pix.gray_level,
                                         rotation_q);
                if (!want.written)
                    o_clipped++;
                pending_results.push_back(want);
            end
            if (i_cfg_we)
                rotation_q = i_cfg_wdata;
        end
        o_pending <= pending_results.size();
    end

endmodule

/* tb/tb_rotated_two_plane_pixel_writer_top.sv */
// ----------------------------------------------------------------------------
// tb_rotated_two_plane_pixel_writer_top
// Drives pixel write beats under all four rotations with random gaps, output
// stalls and one long output hold-off; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb_rotated_two_plane_pixel_writer_top;
    import rtpw_pkg::*;

    localparam int W              = PANEL_WIDTH_DEF;
    localparam int H              = PANEL_HEIGHT_DEF;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 60000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [ROT_W-1:0] cfg_wdata;

    rtpw_in_if  pix_if ();
    rtpw_out_if res_if ();

    int mismatches, pending, checked, clipped;
    int quiet_cycles;
    int sent;
    int lw, lh;
    bit src_gaps;
    bit sink_stalls;
    bit hold_off_req;

    logic [ROT_W-1:0] rot_seq [5] = '{ROT_NONE, ROT_270, ROT_90, ROT_180, ROT_NONE};
    int               rand_cnt [5] = '{200, 200, 200, 150, 100};

    always #5 clk = ~clk;

    rotated_two_plane_pixel_writer_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    rtpw_pixel_write_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .o_pending    (pending),
        .o_mismatches (mismatches),
        .o_checked    (checked),
        .o_clipped    (clipped)
    );

    always @(posedge clk) begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("tb_rotated_two_plane_pixel_writer_top failed");
                $finish;
            end
        end
    end

    // result side: random stalls, long hold-off on request
    initial begin
        int hold_cnt;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                res_if.ready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(posedge clk);
                    hold_cnt++;
                end
                hold_off_req = 1'b0;
            end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end else begin
                res_if.ready <= 1'b1;
                if (!sink_stalls)
                    @(posedge clk);
                else if ($urandom_range(0, 7) == 0)
                    repeat (60) @(posedge clk);
                else
                    repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic send_pixel(input int x, input int y, input int gray);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.pixel_x    <= COORD_W'(x);
        pix_if.pixel_y    <= COORD_W'(y);
        pix_if.gray_level <= GRAY_W'(gray);
        do @(posedge clk); while (!pix_if.ready);
        sent++;
    endtask

    function automatic int boundary_coord(input int lim);
        case ($urandom_range(0, 3))
            0:       return -1;
            1:       return 0;
            2:       return lim - 1;
            default: return lim;
        endcase
    endfunction

    task automatic send_random_pixel();
        int x, y;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // small corner region: repeated hits on the same bytes
            x = $urandom_range(0, 15);
            y = $urandom_range(0, 15);
        end else if (pick < 70) begin
            x = $urandom_range(0, lw - 1);
            y = $urandom_range(0, lh - 1);
        end else if (pick < 82) begin
            x = boundary_coord(lw);
            y = boundary_coord(lh);
        end else begin
            x = $urandom_range(0, 16'hffff);
            y = $urandom_range(0, 16'hffff);
        end
        send_pixel(x, y, $urandom_range(0, 3));
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_rotation(input logic [ROT_W-1:0] rot);
        cfg_we    <= 1'b1;
        cfg_wdata <= rot;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lw = (rot == ROT_90 || rot == ROT_270) ? H : W;
        lh = (rot == ROT_90 || rot == ROT_270) ? W : H;
    endtask

    initial begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= ROT_NONE;
        pix_if.valid      <= 1'b0;
        pix_if.pixel_x    <= '0;
        pix_if.pixel_y    <= '0;
        pix_if.gray_level <= '0;
        sent         = 0;
        src_gaps     = 1'b0;
        sink_stalls  = 1'b0;
        hold_off_req = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        write_rotation(ROT_NONE);

        // same byte rewritten, panel corners, clip edges, sign extremes
        send_pixel(0, 0, 3);
        send_pixel(0, 1, 1);
        send_pixel(0, 7, 2);
        send_pixel(0, 0, 0);
        send_pixel(W - 1, H - 1, 3);
        send_pixel(-1, 5, 3);
        send_pixel(5, -1, 3);
        send_pixel(16'sh7fff, 16'sh8000, 3);
        send_pixel(16'sh8000, 16'sh7fff, 1);

        for (int p = 0; p < 5; p++) begin
            wait_idle();
            write_rotation(rot_seq[p]);
            src_gaps    = (p < 4);
            sink_stalls = (p < 4);
            if (p == 2)
                hold_off_req = 1'b1;
            if (p < 4) begin
                send_pixel(lw - 1, 0, 1);
                send_pixel(0, lh - 1, 2);
                send_pixel(lw, lh - 1, 3);
                send_pixel(lw - 1, lh, 3);
            end
            repeat (rand_cnt[p]) send_random_pixel();
        end

        wait_idle();
        repeat (16) @(posedge clk);
        $display("summary: %0d pixel beats over all four rotations, %0d results checked",
                 sent, checked);
        $display("summary: %0d clipped, %0d mismatches", clipped, mismatches);
        if (mismatches == 0)
            $display("tb_rotated_two_plane_pixel_writer_top passed");
        else
            $display("tb_rotated_two_plane_pixel_writer_top failed");
        $finish;
    end

endmodule
